// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the readout word decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/dewd_pkg.sv
// ----------------------------------------------------------------------------
// dewd_pkg
// Types and constants of the readout word decoder.
// ----------------------------------------------------------------------------
package dewd_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KIND_W     = 4;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned VALUE_W    = 12;
  localparam int unsigned HIT_SLOT_W = 4;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned LEN_W      = 16;

  localparam logic [WORD_W-1:0] HEADER_WORD  = 32'hFFFF_EA0C;
  localparam logic [7:0]        TAG_TDC      = 8'hCC;
  localparam logic [7:0]        TAG_ADC_HIGH = 8'h81;
  localparam logic [7:0]        TAG_ADC_LOW  = 8'h60;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_CNT  = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_IGNORED   = 4'd0,
    KIND_HEADER    = 4'd1,
    KIND_LENGTH    = 4'd2,
    KIND_SKIPPED   = 4'd3,
    KIND_TDC_LEAD  = 4'd4,
    KIND_TDC_TRAIL = 4'd5,
    KIND_ADC_HIGH  = 4'd6,
    KIND_ADC_LOW   = 4'd7,
    KIND_OTHER     = 4'd8
  } word_kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 2'd0,
    ERR_CHAN_RANGE = 2'd1,
    ERR_SLOTS_FULL = 2'd2
  } err_e;

  // Command to one hit counter bank.
  typedef struct packed {
    logic clear;
    logic inc;
  } ctr_cmd_t;

endpackage

// File: hw/rtl/dewd_hit_ctr.sv
// ----------------------------------------------------------------------------
// dewd_hit_ctr
// Bank of per-channel hit counters with bulk clear and single increment.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dewd_hit_ctr #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned MAX_HITS     = 16,
  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_HITS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dewd_pkg::ctr_cmd_t cmd_i,
  input  logic [IDX_W-1:0]   idx_i,
  output logic [CNT_W-1:0]   count_o
);

  logic [CNT_W-1:0] cnt_q [NUM_CHANNELS];
  logic             idx_ok;

  assign idx_ok  = {1'b0, idx_i} < (IDX_W+1)'(NUM_CHANNELS);
  assign count_o = idx_ok ? cnt_q[idx_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) cnt_q[i] <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < NUM_CHANNELS; i++) cnt_q[i] <= '0;
    end else if (cmd_i.inc && idx_ok) begin
      cnt_q[idx_i] <= cnt_q[idx_i] + CNT_W'(1);
    end
  end

  `ASSERT_HOLDS(a_count_bounded, clk_i, rst_ni, count_o <= CNT_W'(MAX_HITS))
  `ASSERT_NEVER(a_inc_when_full, clk_i, rst_ni, cmd_i.inc && count_o >= CNT_W'(MAX_HITS))
  `ASSERT_HOLDS(a_clear_zeroes, clk_i, rst_ni, cmd_i.clear |=> count_o == '0)

endmodule

// File: hw/rtl/daq_event_word_decoder.sv
// ----------------------------------------------------------------------------
// daq_event_word_decoder
// Event-framed readout word decoder with per-channel TDC hit slots.
// ----------------------------------------------------------------------------
// Takes one 32-bit readout word per cycle while neither side stalls and
// returns one decoded result per word: header hunt, length word, skipped
// event counter, then the counted data words split into TDC leading/trailing,
// ADC high/low gain or other. A word is held in the input register and is
// decoded into the result register, with the per-channel counter read and
// increment done in the decode step. Both sides stall independently; a
// header clears all hit counters in the cycle in which it is decoded.
`include "assert_macros.svh"

module daq_event_word_decoder #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned MAX_HITS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dewd_pkg::WORD_W-1:0]         data_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dewd_pkg::KIND_W-1:0]         word_kind_o,
  output logic [dewd_pkg::CHAN_W-1:0]         channel_o,
  output logic [dewd_pkg::VALUE_W-1:0]        value_o,
  output logic [dewd_pkg::HIT_SLOT_W-1:0]     hit_slot_o,
  output logic [dewd_pkg::ERR_W-1:0]          error_o,
  output logic                                last_of_event_o
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_HITS + 1);
  localparam int unsigned SLOT_EXT_W =
      (CNT_W > dewd_pkg::HIT_SLOT_W) ? CNT_W : dewd_pkg::HIT_SLOT_W;

  // Input stage
  logic                        in_valid_q;
  logic [dewd_pkg::WORD_W-1:0] word_q;
  logic                        advance;

  // Event state
  dewd_pkg::phase_e                phase_q, phase_d;
  logic [dewd_pkg::LEN_W-1:0]      words_left_q, words_left_d;

  // Decode results
  dewd_pkg::word_kind_e            kind_d;
  dewd_pkg::err_e                  err_d;
  logic [dewd_pkg::CHAN_W-1:0]     chan_d;
  logic [dewd_pkg::VALUE_W-1:0]    value_d;
  logic [dewd_pkg::HIT_SLOT_W-1:0] slot_d;
  logic                            last_d;
  logic [SLOT_EXT_W-1:0]           slot_ext;
  logic [CNT_W-1:0]                sel_cnt;
  logic                            chan_in_range;

  // Counter banks
  dewd_pkg::ctr_cmd_t  lead_cmd, trail_cmd;
  logic                clear_req, lead_inc, trail_inc;
  logic [IDX_W-1:0]    ctr_idx;
  logic [CNT_W-1:0]    lead_cnt, trail_cnt;

  // Result register
  logic                            out_valid_q;
  logic [dewd_pkg::KIND_W-1:0]     kind_q;
  logic [dewd_pkg::CHAN_W-1:0]     chan_q;
  logic [dewd_pkg::VALUE_W-1:0]    value_q;
  logic [dewd_pkg::HIT_SLOT_W-1:0] slot_q;
  logic [dewd_pkg::ERR_W-1:0]      err_q;
  logic                            last_q;

  // Handshake: move a word on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (in_ready_o && in_valid_i) begin
      word_q <= data_word_i;
    end
  end

  assign chan_in_range = {1'b0, word_q[23:16]} < (dewd_pkg::CHAN_W+1)'(NUM_CHANNELS);
  assign ctr_idx       = word_q[16 +: IDX_W];

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= dewd_pkg::PH_HUNT;
      words_left_q <= '0;
    end else if (advance) begin
      phase_q      <= phase_d;
      words_left_q <= words_left_d;
    end
  end

  // Next phase and decode
  always_comb begin
    phase_d      = phase_q;
    words_left_d = words_left_q;
    kind_d       = dewd_pkg::KIND_IGNORED;
    err_d        = dewd_pkg::ERR_OK;
    chan_d       = '0;
    value_d      = '0;
    slot_ext     = '0;
    last_d       = 1'b0;
    clear_req    = 1'b0;
    lead_inc     = 1'b0;
    trail_inc    = 1'b0;
    sel_cnt      = '0;

    unique case (phase_q)
      dewd_pkg::PH_HUNT: begin
        if (word_q == dewd_pkg::HEADER_WORD) begin
          kind_d    = dewd_pkg::KIND_HEADER;
          clear_req = 1'b1;
          phase_d   = dewd_pkg::PH_LEN;
        end
      end
      dewd_pkg::PH_LEN: begin
        kind_d       = dewd_pkg::KIND_LENGTH;
        words_left_d = word_q[dewd_pkg::LEN_W-1:0];
        phase_d      = dewd_pkg::PH_CNT;
      end
      dewd_pkg::PH_CNT: begin
        kind_d = dewd_pkg::KIND_SKIPPED;
        if (words_left_q == '0) begin
          last_d  = 1'b1;
          phase_d = dewd_pkg::PH_HUNT;
        end else begin
          phase_d = dewd_pkg::PH_DATA;
        end
      end
      dewd_pkg::PH_DATA: begin
        unique case (word_q[31:24])
          dewd_pkg::TAG_TDC:
            kind_d = word_q[15] ? dewd_pkg::KIND_TDC_TRAIL : dewd_pkg::KIND_TDC_LEAD;
          dewd_pkg::TAG_ADC_HIGH: kind_d = dewd_pkg::KIND_ADC_HIGH;
          dewd_pkg::TAG_ADC_LOW:  kind_d = dewd_pkg::KIND_ADC_LOW;
          default:                kind_d = dewd_pkg::KIND_OTHER;
        endcase

        if (kind_d != dewd_pkg::KIND_OTHER) begin
          chan_d  = word_q[23:16];
          value_d = word_q[dewd_pkg::VALUE_W-1:0];
          if (!chan_in_range) begin
            err_d = dewd_pkg::ERR_CHAN_RANGE;
          end else if (kind_d == dewd_pkg::KIND_TDC_LEAD ||
                       kind_d == dewd_pkg::KIND_TDC_TRAIL) begin
            sel_cnt = (kind_d == dewd_pkg::KIND_TDC_LEAD) ? lead_cnt : trail_cnt;
            if (sel_cnt >= CNT_W'(MAX_HITS)) begin
              // Drop the hit, counter stays at the limit.
              err_d = dewd_pkg::ERR_SLOTS_FULL;
            end else begin
              slot_ext  = SLOT_EXT_W'(sel_cnt);
              lead_inc  = (kind_d == dewd_pkg::KIND_TDC_LEAD);
              trail_inc = (kind_d == dewd_pkg::KIND_TDC_TRAIL);
            end
          end
        end

        words_left_d = words_left_q - dewd_pkg::LEN_W'(1);
        if (words_left_d == '0) begin
          last_d  = 1'b1;
          phase_d = dewd_pkg::PH_HUNT;
        end
      end
      default: phase_d = dewd_pkg::PH_HUNT;
    endcase

    slot_d = slot_ext[dewd_pkg::HIT_SLOT_W-1:0];
  end

  assign lead_cmd  = '{clear: advance && clear_req, inc: advance && lead_inc};
  assign trail_cmd = '{clear: advance && clear_req, inc: advance && trail_inc};

  dewd_hit_ctr #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_HITS     (MAX_HITS)
  ) u_lead_ctr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lead_cmd),
    .idx_i   (ctr_idx),
    .count_o (lead_cnt)
  );

  dewd_hit_ctr #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_HITS     (MAX_HITS)
  ) u_trail_ctr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (trail_cmd),
    .idx_i   (ctr_idx),
    .count_o (trail_cnt)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      value_q <= value_d;
      slot_q  <= slot_d;
      err_q   <= err_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_kind_o     = kind_q;
  assign channel_o       = chan_q;
  assign value_o         = value_q;
  assign hit_slot_o      = slot_q;
  assign error_o         = err_q;
  assign last_of_event_o = last_q;

  `ASSERT_HOLDS(a_full_only_tdc, clk_i, rst_ni,
    (out_valid_q && err_q == dewd_pkg::ERR_SLOTS_FULL) |->
      (kind_q == dewd_pkg::KIND_TDC_LEAD || kind_q == dewd_pkg::KIND_TDC_TRAIL))
  `ASSERT_HOLDS(a_last_kind, clk_i, rst_ni,
    (out_valid_q && last_q) |->
      (kind_q != dewd_pkg::KIND_IGNORED && kind_q != dewd_pkg::KIND_HEADER &&
       kind_q != dewd_pkg::KIND_LENGTH))
  `ASSERT_HOLDS(a_slot_only_tdc_ok, clk_i, rst_ni,
    (out_valid_q && slot_q != '0) |->
      ((kind_q == dewd_pkg::KIND_TDC_LEAD || kind_q == dewd_pkg::KIND_TDC_TRAIL) &&
       err_q == dewd_pkg::ERR_OK))
  `ASSERT_HOLDS(a_last_returns_hunt, clk_i, rst_ni,
    (advance && last_d) |=> phase_q == dewd_pkg::PH_HUNT)

endmodule
